// ===== sv/pll_pkg.sv =====
// Package for the positional list block: operation and status codes,
// cell command type shared by the control unit and the slot cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pll_pkg;

    // Width of a slot index carried to the cells (covers up to 1024 slots)
    localparam int AT_BITS = 10;

    typedef enum logic [3:0] {
        OP_APPEND    = 4'd0,
        OP_PUSH      = 4'd1,
        OP_INSERT    = 4'd2,
        OP_POP_FRONT = 4'd3,
        OP_POP_BACK  = 4'd4,
        OP_REMOVE    = 4'd5,
        OP_READ      = 4'd6,
        OP_WRITE     = 4'd7,
        OP_CLEAR     = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // What every cell does this cycle, relative to the slot index 'at'
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,  // at loads new word, above takes from below
        CELL_REMOVE = 3'd2,  // at and above take from the cell above
        CELL_WRITE  = 3'd3,  // at loads new word
        CELL_CLEAR  = 3'd4   // every cell goes to zero
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t         kind;
        logic [AT_BITS-1:0] at;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pll_if.sv =====
// Valid/ready channel interfaces for the positional list block:
// one for operation items, one for result items. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface pll_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         op;
    logic signed [31:0] data_in;
    logic [5:0]         position;

    modport source (output valid, output op, output data_in, output position, input ready);
    modport sink   (input valid, input op, input data_in, input position, output ready);
endinterface

interface pll_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_out;
    logic [6:0]         length_out;
    logic [1:0]         status;

    modport source (output valid, output data_out, output length_out, output status,
                    input ready);
    modport sink   (input valid, input data_out, input length_out, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/pll_cell.sv =====
// One slot cell of the list chain: holds a word and takes it from its
// lower or upper neighbor, from the write bus, or clears. Uses pll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pll_cell #(
    parameter int WORD_BITS = 32,
    parameter int INDEX     = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  pll_pkg::cell_cmd_t ctl,
    input  wire  [WORD_BITS-1:0]     wdata,
    input  wire  [WORD_BITS-1:0]     lower,
    input  wire  [WORD_BITS-1:0]     upper,
    output logic [WORD_BITS-1:0]     value
);

    localparam logic [pll_pkg::AT_BITS-1:0] MY_AT = pll_pkg::AT_BITS'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 is_at;
    logic                 is_above;

    assign is_at    = (ctl.at == MY_AT);
    assign is_above = (MY_AT > ctl.at);

    // next word for this slot
    always_comb
    begin
        word_next = word_reg;
        unique case (ctl.kind)
            pll_pkg::CELL_INSERT:
            begin
                if (is_at)
                    word_next = wdata;
                else if (is_above)
                    word_next = lower;
            end
            pll_pkg::CELL_REMOVE:
            begin
                if (is_at || is_above)
                    word_next = upper;
            end
            pll_pkg::CELL_WRITE:
            begin
                if (is_at)
                    word_next = wdata;
            end
            pll_pkg::CELL_CLEAR:
            begin
                word_next = '0;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign value = word_reg;

endmodule

`default_nettype wire

// ===== sv/pll_ctrl.sv =====
// Control unit of the positional list: length counter, operation decode,
// cell command broadcast and the result register. Uses pll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pll_ctrl #(
    parameter int MAX_ENTRIES = 64,
    parameter int WORD_BITS   = 32
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // operation item
    input  wire                            cmd_valid,
    output logic                           cmd_ready,
    input  wire  [3:0]                     op,
    input  wire  [5:0]                     position,
    // result item
    output logic                           rsp_valid,
    input  wire                            rsp_ready,
    output logic [31:0]                    data_out,
    output logic [6:0]                     length_out,
    output logic [1:0]                     status,
    // chain side
    output pll_pkg::cell_cmd_t             cell_ctl,
    output logic [pll_pkg::AT_BITS-1:0]    rd_at,
    input  wire  [WORD_BITS-1:0]           rd_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   rsp_valid_reg;
    logic [31:0]            dout_reg;
    logic [6:0]             len_reg;
    pll_pkg::status_t       st_reg;

    logic                   accept;
    logic [15:0]            cnt16;
    logic [15:0]            pos16;
    logic [15:0]            at16;
    logic [15:0]            len16;
    logic                   full;
    logic                   empty;
    logic                   take_read;
    pll_pkg::cell_kind_t    kind;
    pll_pkg::status_t       st;
    logic [15:0]            cnt16_next;
    logic [63:0]            rd_ext;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    assign cnt16 = 16'(count_reg);
    assign pos16 = 16'(position);
    assign full  = (cnt16 == 16'(MAX_ENTRIES));
    assign empty = (cnt16 == 16'd0);

    // decode the operation against the current length
    always_comb
    begin
        kind       = pll_pkg::CELL_HOLD;
        st         = pll_pkg::ST_OK;
        at16       = 16'd0;
        take_read  = 1'b0;
        cnt16_next = cnt16;
        unique case (op)
            pll_pkg::OP_APPEND:
            begin
                if (full)
                    st = pll_pkg::ST_FULL;
                else
                begin
                    kind       = pll_pkg::CELL_INSERT;
                    at16       = cnt16;
                    cnt16_next = cnt16 + 16'd1;
                end
            end
            pll_pkg::OP_PUSH:
            begin
                if (full)
                    st = pll_pkg::ST_FULL;
                else
                begin
                    kind       = pll_pkg::CELL_INSERT;
                    cnt16_next = cnt16 + 16'd1;
                end
            end
            pll_pkg::OP_INSERT:
            begin
                if (pos16 > cnt16)
                    st = pll_pkg::ST_BADPOS;
                else if (full)
                    st = pll_pkg::ST_FULL;
                else
                begin
                    kind       = pll_pkg::CELL_INSERT;
                    at16       = pos16;
                    cnt16_next = cnt16 + 16'd1;
                end
            end
            pll_pkg::OP_POP_FRONT:
            begin
                if (empty)
                    st = pll_pkg::ST_EMPTY;
                else
                begin
                    kind       = pll_pkg::CELL_REMOVE;
                    take_read  = 1'b1;
                    cnt16_next = cnt16 - 16'd1;
                end
            end
            pll_pkg::OP_POP_BACK:
            begin
                if (empty)
                    st = pll_pkg::ST_EMPTY;
                else
                begin
                    kind       = pll_pkg::CELL_REMOVE;
                    at16       = cnt16 - 16'd1;
                    take_read  = 1'b1;
                    cnt16_next = cnt16 - 16'd1;
                end
            end
            pll_pkg::OP_REMOVE:
            begin
                if (empty)
                    st = pll_pkg::ST_EMPTY;
                else if (pos16 >= cnt16)
                    st = pll_pkg::ST_BADPOS;
                else
                begin
                    kind       = pll_pkg::CELL_REMOVE;
                    at16       = pos16;
                    take_read  = 1'b1;
                    cnt16_next = cnt16 - 16'd1;
                end
            end
            pll_pkg::OP_READ:
            begin
                if (pos16 >= cnt16)
                    st = pll_pkg::ST_BADPOS;
                else
                begin
                    at16      = pos16;
                    take_read = 1'b1;
                end
            end
            pll_pkg::OP_WRITE:
            begin
                if (pos16 >= cnt16)
                    st = pll_pkg::ST_BADPOS;
                else
                begin
                    kind = pll_pkg::CELL_WRITE;
                    at16 = pos16;
                end
            end
            pll_pkg::OP_CLEAR:
            begin
                kind       = pll_pkg::CELL_CLEAR;
                cnt16_next = 16'd0;
            end
            default:
            begin
                kind = pll_pkg::CELL_HOLD;
            end
        endcase
    end

    // cells only move on an accepted item
    assign cell_ctl.kind = accept ? kind : pll_pkg::CELL_HOLD;
    assign cell_ctl.at   = at16[pll_pkg::AT_BITS-1:0];
    assign rd_at         = at16[pll_pkg::AT_BITS-1:0];

    assign count_next = accept ? cnt16_next[CNT_W-1:0] : count_reg;
    assign len16      = cnt16_next;
    assign rd_ext     = 64'(rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result register, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dout_reg <= take_read ? rd_ext[31:0] : 32'd0;
            len_reg  <= len16[6:0];
            st_reg   <= st;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign data_out   = dout_reg;
    assign length_out = len_reg;
    assign status     = st_reg;

endmodule

`default_nettype wire

// ===== sv/positional_list_insert_remove.sv =====
// Top level of the positional list: control unit and the chain of slot cells.
// Uses pll_pkg, pll_cmd_if, pll_rsp_if, pll_ctrl and pll_cell.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to MAX_ENTRIES words of WORD_BITS bits. Every operation
// item (append, push front, insert, pop front, pop back, remove, read,
// write, clear) gives one result item with the removed or read word, the
// new length and a status. Each slot is a cell in a chain; an insert or
// remove shifts every cell above the position in the same cycle, so the
// block takes one item per clock while the result side keeps up. The
// result sits in an output register, and a new item is taken in the cycle
// the previous result is taken. Reset clears all slots and the length.
module positional_list_insert_remove #(
    parameter int MAX_ENTRIES = 64,
    parameter int WORD_BITS   = 32
) (
    input  wire           clk,
    input  wire           rst_n,
    pll_cmd_if.sink       cmd,
    pll_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    pll_pkg::cell_cmd_t             cell_ctl;
    logic [pll_pkg::AT_BITS-1:0]    rd_at;
    logic [WORD_BITS-1:0]           rd_data;
    logic [WORD_BITS-1:0]           slot_val [MAX_ENTRIES];
    logic [63:0]                    din_ext;
    logic [WORD_BITS-1:0]           wdata;
    logic [31:0]                    dout;

    // stored words keep the low bits of the zero-extended input
    assign din_ext = {32'd0, cmd.data_in};
    assign wdata   = din_ext[WORD_BITS-1:0];

    pll_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_BITS   (WORD_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .op         (cmd.op),
        .position   (cmd.position),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .data_out   (dout),
        .length_out (rsp.length_out),
        .status     (rsp.status),
        .cell_ctl   (cell_ctl),
        .rd_at      (rd_at),
        .rd_data    (rd_data)
    );

    assign rsp.data_out = dout;

    // chain of slot cells; bottom neighbor and top neighbor read as zero
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] lower_w;
        logic [WORD_BITS-1:0] upper_w;

        if (i == 0)
        begin : g_bot
            assign lower_w = '0;
        end
        else
        begin : g_mid_lo
            assign lower_w = slot_val[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_top
            assign upper_w = '0;
        end
        else
        begin : g_mid_hi
            assign upper_w = slot_val[i+1];
        end

        pll_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl),
            .wdata (wdata),
            .lower (lower_w),
            .upper (upper_w),
            .value (slot_val[i])
        );
    end

    // word at the read position (only used when the position is valid)
    assign rd_data = slot_val[rd_at[IDX_W-1:0]];

endmodule

`default_nettype wire

// ===== tb/sv/tb_positional_list_insert_remove.sv =====
// Testbench for positional_list_insert_remove: random and directed list operations
// with an operation-level predictor and random stalls on both channels.
// Depends on pll_pkg, pll_cmd_if / pll_rsp_if and the top-level RTL.
`timescale 1ns / 1ps

module tb_positional_list_insert_remove;

    localparam int LIST_DEPTH    = 64;
    localparam int RANDOM_OPS    = 1730;
    localparam int IDLE_LIMIT    = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 900;
    localparam int DRAIN_CYCLES  = 20;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] data;
        logic [5:0]  pos;
    } list_cmd_t;

    typedef struct {
        logic [31:0]      data;
        logic [6:0]       length;
        pll_pkg::status_t status;
    } list_result_t;

    logic clk;
    logic rst_n = 1'b0;

    pll_cmd_if cmd_ch ();
    pll_rsp_if rsp_ch ();

    positional_list_insert_remove #(
        .MAX_ENTRIES (LIST_DEPTH),
        .WORD_BITS   (32)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Predicted list contents
    logic [31:0]  list_words [LIST_DEPTH];
    int           list_len;

    list_cmd_t    ops_to_send [$];
    list_result_t results_due [$];

    int op_total;
    int ops_accepted;
    int results_checked;
    int fail_count;
    int gen_len;
    int cycle_count;
    int idle_cycles;

    // Clock, and known values on every input from time zero
    initial
    begin
        clk = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.op       = '0;
        cmd_ch.data_in  = '0;
        cmd_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long; quiet stretches have none
    function automatic int pick_gap();
        int r;
        if (((cycle_count / 500) % 4) == 3)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic open_slot(input int at, input logic [31:0] w);
        int k;
        for (k = list_len; k > at; k--)
            list_words[k] = list_words[k-1];
        list_words[at] = w;
        list_len++;
    endtask

    task automatic close_slot(input int at, output logic [31:0] w);
        int k;
        w = list_words[at];
        for (k = at; k + 1 < list_len; k++)
            list_words[k] = list_words[k+1];
        list_words[list_len-1] = '0;
        list_len--;
    endtask

    task automatic list_apply(input list_cmd_t c);
        list_result_t r;
        int           k;
        r.data   = '0;
        r.status = pll_pkg::ST_OK;
        case (c.op)
            pll_pkg::OP_APPEND, pll_pkg::OP_PUSH:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = pll_pkg::ST_FULL;
                else
                    open_slot((c.op == pll_pkg::OP_APPEND) ? list_len : 0, c.data);
            end
            pll_pkg::OP_INSERT:
            begin
                // position past the end is checked before fullness
                if (int'(c.pos) > list_len)
                    r.status = pll_pkg::ST_BADPOS;
                else if (list_len >= LIST_DEPTH)
                    r.status = pll_pkg::ST_FULL;
                else
                    open_slot(c.pos, c.data);
            end
            pll_pkg::OP_POP_FRONT, pll_pkg::OP_POP_BACK:
            begin
                if (list_len == 0)
                    r.status = pll_pkg::ST_EMPTY;
                else
                    close_slot((c.op == pll_pkg::OP_POP_FRONT) ? 0 : list_len - 1,
                               r.data);
            end
            pll_pkg::OP_REMOVE:
            begin
                // empty list wins over a bad position
                if (list_len == 0)
                    r.status = pll_pkg::ST_EMPTY;
                else if (int'(c.pos) >= list_len)
                    r.status = pll_pkg::ST_BADPOS;
                else
                    close_slot(c.pos, r.data);
            end
            pll_pkg::OP_READ:
            begin
                if (int'(c.pos) >= list_len)
                    r.status = pll_pkg::ST_BADPOS;
                else
                    r.data = list_words[c.pos];
            end
            pll_pkg::OP_WRITE:
            begin
                if (int'(c.pos) >= list_len)
                    r.status = pll_pkg::ST_BADPOS;
                else
                    list_words[c.pos] = c.data;
            end
            pll_pkg::OP_CLEAR:
            begin
                for (k = 0; k < LIST_DEPTH; k++)
                    list_words[k] = '0;
                list_len = 0;
            end
            default:
            begin
                // unknown op: nothing changes
            end
        endcase
        r.length = list_len[6:0];
        results_due.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Stimulus generation, tracking the length to steer positions
    // ---------------------------------------------------------------
    task automatic queue_op(input logic [3:0] op, input logic [31:0] data,
                            input logic [5:0] pos);
        list_cmd_t c;
        c.op   = op;
        c.data = data;
        c.pos  = pos;
        ops_to_send.push_back(c);
        case (op)
            pll_pkg::OP_APPEND, pll_pkg::OP_PUSH:
                if (gen_len < LIST_DEPTH) gen_len++;
            pll_pkg::OP_INSERT:
                if (int'(pos) <= gen_len && gen_len < LIST_DEPTH) gen_len++;
            pll_pkg::OP_POP_FRONT, pll_pkg::OP_POP_BACK:
                if (gen_len > 0) gen_len--;
            pll_pkg::OP_REMOVE:
                if (gen_len > 0 && int'(pos) < gen_len) gen_len--;
            pll_pkg::OP_CLEAR:
                gen_len = 0;
            default:
                ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid position up to top, sometimes any position at all
    function automatic logic [5:0] rand_pos(input int top);
        if ($urandom_range(0, 9) == 0 || top < 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, (top > 63) ? 63 : top));
    endfunction

    task automatic queue_random(input int idx);
        int          phase;
        int          r;
        int          grow_pct;
        int          shrink_pct;
        logic [3:0]  op;
        phase = (idx / 120) % 3;
        // fill, mixed and drain phases so the list hits both full and empty
        grow_pct   = (phase == 0) ? 70 : (phase == 1) ? 35 : 15;
        shrink_pct = (phase == 0) ? 15 : (phase == 1) ? 35 : 70;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 4)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_op(pll_pkg::OP_CLEAR, rand_word(), rand_pos(-1));
            else
                queue_op(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), rand_word(),
                         rand_pos(-1));
        end
        else if (r < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = pll_pkg::OP_APPEND;
                1:       op = pll_pkg::OP_PUSH;
                default: op = pll_pkg::OP_INSERT;
            endcase
            queue_op(op, rand_word(), rand_pos(gen_len));
        end
        else if (r < grow_pct + shrink_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = pll_pkg::OP_POP_FRONT;
                1:       op = pll_pkg::OP_POP_BACK;
                default: op = pll_pkg::OP_REMOVE;
            endcase
            queue_op(op, rand_word(), rand_pos(gen_len - 1));
        end
        else
        begin
            op = $urandom_range(0, 1) ? pll_pkg::OP_READ : pll_pkg::OP_WRITE;
            queue_op(op, rand_word(), rand_pos(gen_len - 1));
        end
    endtask

    // ---------------------------------------------------------------
    // Operation driver
    // ---------------------------------------------------------------
    int send_wait;

    always @(posedge clk or negedge rst_n)
    begin : drive_ops
        list_cmd_t nxt;
        list_cmd_t took;
        if (!rst_n)
        begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.op       <= '0;
            cmd_ch.data_in  <= '0;
            cmd_ch.position <= '0;
            send_wait = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                took.op   = cmd_ch.op;
                took.data = cmd_ch.data_in;
                took.pos  = cmd_ch.position;
                list_apply(took);
                ops_accepted++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (ops_to_send.size() != 0)
                begin
                    nxt = ops_to_send.pop_front();
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.op       <= nxt.op;
                    cmd_ch.data_in  <= nxt.data;
                    cmd_ch.position <= nxt.pos;
                    send_wait = pick_gap();
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stalls
    // ---------------------------------------------------------------
    int hold_left;
    bit long_hold_done;

    always @(posedge clk or negedge rst_n)
    begin : check_results
        list_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked++;
                if (results_due.size() == 0)
                begin
                    $error("result item with no operation outstanding");
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.data_out !== want.data)
                    begin
                        $error("data_out: expected %0d, got %0d",
                               $signed(want.data), rsp_ch.data_out);
                        fail_count++;
                    end
                    if (rsp_ch.length_out !== want.length)
                    begin
                        $error("length_out: expected %0d, got %0d",
                               want.length, rsp_ch.length_out);
                        fail_count++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp_ch.status);
                        fail_count++;
                    end
                end
                // one long hold-off so the block backs up and stalls its input
                if (!long_hold_done && results_checked == HOLD_AFTER)
                begin
                    hold_left = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin : run_test
        int i;
        for (i = 0; i < LIST_DEPTH; i++)
            list_words[i] = '0;
        list_len        = 0;
        gen_len         = 0;
        ops_accepted    = 0;
        results_checked = 0;
        fail_count      = 0;
        cycle_count     = 0;
        idle_cycles     = 0;
        long_hold_done  = 1'b0;

        // Directed: empty list, bad positions, extremes, unknown ops, clear
        queue_op(pll_pkg::OP_POP_FRONT, 32'h0,         6'd0);
        queue_op(pll_pkg::OP_POP_BACK,  32'h0,         6'd0);
        queue_op(pll_pkg::OP_REMOVE,    32'h0,         6'd0);
        queue_op(pll_pkg::OP_REMOVE,    32'h0,         6'd63);
        queue_op(pll_pkg::OP_READ,      32'h0,         6'd0);
        queue_op(pll_pkg::OP_WRITE,     32'h1234_5678, 6'd0);
        queue_op(pll_pkg::OP_INSERT,    32'h1,         6'd1);
        queue_op(pll_pkg::OP_INSERT,    32'h7fff_ffff, 6'd0);
        queue_op(pll_pkg::OP_APPEND,    32'h8000_0000, 6'd0);
        queue_op(pll_pkg::OP_PUSH,      32'hffff_ffff, 6'd0);
        queue_op(pll_pkg::OP_INSERT,    32'h5555_5555, 6'd3);
        queue_op(pll_pkg::OP_INSERT,    32'h2,         6'd5);
        queue_op(pll_pkg::OP_READ,      32'h0,         6'd0);
        queue_op(pll_pkg::OP_READ,      32'h0,         6'd3);
        queue_op(pll_pkg::OP_READ,      32'h0,         6'd4);
        queue_op(pll_pkg::OP_WRITE,     32'haaaa_aaaa, 6'd1);
        queue_op(pll_pkg::OP_READ,      32'h0,         6'd1);
        queue_op(pll_pkg::OP_REMOVE,    32'h0,         6'd63);
        queue_op(pll_pkg::OP_REMOVE,    32'h0,         6'd1);
        queue_op(pll_pkg::OP_POP_FRONT, 32'h0,         6'd0);
        queue_op(pll_pkg::OP_POP_BACK,  32'h0,         6'd0);
        queue_op(OP_UNUSED_LO,          32'hffff_ffff, 6'd63);
        queue_op(OP_UNUSED_HI,          32'h0,         6'd0);
        queue_op(pll_pkg::OP_CLEAR,     32'hffff_ffff, 6'd63);
        queue_op(pll_pkg::OP_READ,      32'h0,         6'd0);

        for (i = 0; i < RANDOM_OPS; i++)
            queue_random(i);
        op_total = ops_to_send.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted < op_total)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pll_pkg.sv
sv/pll_if.sv
sv/pll_cell.sv
sv/pll_ctrl.sv
sv/positional_list_insert_remove.sv
tb/sv/tb_positional_list_insert_remove.sv
